// ----- src/imutyt_pkg.sv -----
// Shared types, constants and helper functions for the IMU tilt and yaw tracker.
// Used by the controller, the datapath and the top level.
package imutyt_pkg;

   localparam int CAL_SAMPLES_DEF  = 100;
   localparam int CORDIC_ITERS_DEF = 16;
   localparam int STEP_W           = 5;
   localparam int SQRT_STEPS       = 32;

   localparam logic [19:0]        YAW_GAIN_RST = 20'd6557;
   localparam logic signed [29:0] ROLL_BASE    = 30'sd188743680;
   localparam logic signed [41:0] YAW_HALF     = 42'sd773094113280;
   localparam logic signed [41:0] YAW_FULL     = 42'sd1546188226560;
   localparam logic signed [16:0] PITCH_LIM    = 17'sd11520;
   localparam logic signed [16:0] ROLL_LIM     = 17'sd23040;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAL,
      ST_CHK,
      ST_DIV,
      ST_BIAS,
      ST_START,
      ST_ROLL,
      ST_PLOAD,
      ST_PITCH,
      ST_WRAP,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic              load;
      logic              square;
      logic              cal_acc;
      logic              div_load;
      logic              div_step;
      logic              bias_set;
      logic              start;
      logic              sqrt_step;
      logic              cordic_step;
      logic              pitch_load;
      logic              yaw_wrap;
      logic              out_load;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic calibrated;
      logic cal_full;
      logic out_free;
   } status_type;

   function automatic logic [25:0] atan_lut(input logic [STEP_W-1:0] idx);
      logic [25:0] v;
      unique case (idx)
         5'd0:    v = 26'd47185920;
         5'd1:    v = 26'd27855475;
         5'd2:    v = 26'd14718068;
         5'd3:    v = 26'd7471121;
         5'd4:    v = 26'd3750058;
         5'd5:    v = 26'd1876857;
         5'd6:    v = 26'd938658;
         5'd7:    v = 26'd469357;
         5'd8:    v = 26'd234682;
         5'd9:    v = 26'd117342;
         5'd10:   v = 26'd58671;
         5'd11:   v = 26'd29335;
         5'd12:   v = 26'd14668;
         5'd13:   v = 26'd7334;
         5'd14:   v = 26'd3667;
         5'd15:   v = 26'd1833;
         5'd16:   v = 26'd917;
         5'd17:   v = 26'd458;
         5'd18:   v = 26'd229;
         5'd19:   v = 26'd115;
         5'd20:   v = 26'd57;
         5'd21:   v = 26'd29;
         5'd22:   v = 26'd14;
         5'd23:   v = 26'd7;
         default: v = 26'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [16:0] sat_angle(input logic signed [29:0] z,
                                                    input logic signed [16:0] lim);
      logic signed [29:0] r;
      logic signed [16:0] q;
      r = (z + 30'sd4096) >>> 13;
      q = r[16:0];
      if (q > lim) begin
         q = lim;
      end else if (q < -lim) begin
         q = -lim;
      end
      return q;
   endfunction

endpackage

// ----- src/imu_tilt_and_yaw_tracker_unit.sv -----
// Top level of the IMU tilt and yaw tracker: joins controller and datapath.
// Depends on imutyt_pkg, imutyt_ctrl and imutyt_dpath.
//
// Use: one raw sample enters on the req_ stream (accel x, y, z, gyro z). The
// first CAL_SAMPLES samples build the gyro bias and give no transaction on
// rsp_, except the last of them; every later sample gives one transaction
// with pitch, roll and integrated yaw in 1/128 degree.
// csr_wen/csr_wdata set the yaw gain; write it only while the block is idle.
// An ordinary sample runs ST_CAL, ST_START, ST_ROLL, ST_PLOAD, ST_PITCH, ST_WRAP
// and ST_PUSH; the bias-setting sample adds ST_CHK, ST_DIV and ST_BIAS for the
// reciprocal-multiply division. One item is in work at a time: a new sample is
// taken only after the last leaves ST_PUSH. The 32-step square root, overlapped
// with roll rotations, and the shared CORDIC's pitch rotations fill most of it.
// The result register frees the core: a new sample is taken while a result
// still waits; a stalled receiver holds the next result in its final state.
// Reset (synchronous) clears calibration, bias, yaw and the gain to its default.
module imu_tilt_and_yaw_tracker_unit
   import imutyt_pkg::*;
#(
   parameter int CAL_SAMPLES  = CAL_SAMPLES_DEF,
   parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // accel_x, accel_y, accel_z, gyro_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pitch_angle, roll_angle, yaw_angle, pad
   input  logic        csr_wen,
   input  logic [19:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   imutyt_ctrl #(
      .CORDIC_ITERS(CORDIC_ITERS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   imutyt_dpath #(
      .CAL_SAMPLES(CAL_SAMPLES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef SYNTHESIS
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while one is in work");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) <= 15'sd11520 &&
                      $signed(rsp_tdata[14:0]) >= -15'sd11520 &&
                      $signed(rsp_tdata[30:15]) <= 16'sd23040 &&
                      $signed(rsp_tdata[30:15]) >= -16'sd23040))
      else $error("tilt angle out of range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[46:31]) <= 16'sd23040 &&
                      $signed(rsp_tdata[46:31]) >= -16'sd23040))
      else $error("yaw not wrapped");
`endif

endmodule

// ----- src/imutyt_ctrl.sv -----
// Sequencer for the IMU tilt and yaw tracker: calibration, division, square root
// and CORDIC phases. Depends on imutyt_pkg; drives imutyt_dpath through cmd_type.
module imutyt_ctrl
   import imutyt_pkg::*;
#(
   parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              roll_last, pitch_last;

   assign roll_last  = step_ff == STEP_W'(SQRT_STEPS - 1);
   assign pitch_last = step_ff == STEP_W'(CORDIC_ITERS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_CAL;
         ST_CAL:   state_in = status.calibrated ? ST_START : ST_CHK;
         ST_CHK:   state_in = status.cal_full ? ST_DIV : ST_IDLE;
         ST_DIV:   state_in = ST_BIAS;
         ST_BIAS:  state_in = ST_START;
         ST_START: state_in = ST_ROLL;
         ST_ROLL:  if (roll_last) state_in = ST_PLOAD;
         ST_PLOAD: state_in = ST_PITCH;
         ST_PITCH: if (pitch_last) state_in = ST_WRAP;
         ST_WRAP:  state_in = ST_PUSH;
         ST_PUSH:  if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.step   = step_ff;
      req_tready = 1'b0;
      step_in    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CAL: begin
            cmd.square  = 1'b1;
            cmd.cal_acc = !status.calibrated;
         end
         ST_CHK:   cmd.div_load = status.cal_full;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_BIAS:  cmd.bias_set = 1'b1;
         ST_START: cmd.start = 1'b1;
         ST_ROLL: begin
            cmd.sqrt_step   = 1'b1;
            cmd.cordic_step = step_ff < STEP_W'(CORDIC_ITERS);
            step_in         = step_ff + 1'b1;
         end
         ST_PLOAD: cmd.pitch_load = 1'b1;
         ST_PITCH: begin
            cmd.cordic_step = 1'b1;
            step_in         = step_ff + 1'b1;
         end
         ST_WRAP:  cmd.yaw_wrap = 1'b1;
         ST_PUSH:  cmd.out_load = status.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

// ----- src/imutyt_dpath.sv -----
// Datapath of the IMU tilt and yaw tracker: bias calibration and divider, square
// root, shared CORDIC, yaw integrator and result register. Depends on imutyt_pkg.
module imutyt_dpath
   import imutyt_pkg::*;
#(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] req_tdata,
   input  logic        csr_wen,
   input  logic [19:0] csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  cmd_type     cmd,
   output status_type  status
);

   // exact floor division of a 30-bit numerator by CAL_SAMPLES
   localparam int              DIV_SHIFT = 30 + $clog2(CAL_SAMPLES);
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);

   logic signed [15:0] ax_ff, ay_ff, az_ff, gz_ff;
   logic [30:0]        sqy_ff, sqz_ff;
   logic signed [31:0] sqy_full, sqz_full;
   logic [19:0]        gain_ff;

   logic [6:0]         count_ff;
   logic signed [23:0] sum_ff;
   logic               calib_ff;
   logic signed [23:0] bias_ff;

   logic [29:0]        num_ff;
   logic [23:0]        quo_ff;
   logic               neg_ff;
   logic [29:0]        num_abs;
   logic [61:0]        div_prod;

   logic [31:0]        rad_ff, root_ff;
   logic [33:0]        srem_ff;
   logic [35:0]        sq_t, sq_trial;

   logic signed [35:0] cx_ff, cy_ff, xs, ys, ax36, az36;
   logic signed [29:0] cz_ff, rollz_ff, atan_v;
   logic               czero_ff;

   logic signed [45:0] prod_ff;
   logic signed [24:0] diff;
   logic signed [41:0] yaw_ff, yaw_rnd;

   logic               out_valid_ff;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] roll_ff, yawo_ff;
   logic signed [16:0] pitch_sat, roll_sat;

   assign sqy_full = ay_ff * ay_ff;
   assign sqz_full = az_ff * az_ff;
   assign ax36     = {{4{ax_ff[15]}}, ax_ff, 16'b0};
   assign az36     = {{4{az_ff[15]}}, az_ff, 16'b0};
   assign num_abs  = 30'((sum_ff[23] ? -{sum_ff, 8'b0} : {sum_ff, 8'b0})
                         + 32'(CAL_SAMPLES / 2));
   assign div_prod = 62'(num_ff) * 62'(DIV_RECIP);
   assign sq_t     = {srem_ff, rad_ff[31:30]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign xs       = cx_ff >>> cmd.step;
   assign ys       = cy_ff >>> cmd.step;
   assign atan_v   = $signed({4'b0, atan_lut(cmd.step)});
   assign diff     = $signed({gz_ff[15], gz_ff, 8'b0}) - $signed({bias_ff[23], bias_ff});
   assign yaw_rnd  = yaw_ff + (42'sd1 <<< 24);
   assign pitch_sat = sat_angle(cz_ff, PITCH_LIM);
   assign roll_sat  = sat_angle(rollz_ff, ROLL_LIM);

   assign status.calibrated = calib_ff;
   assign status.cal_full   = count_ff == 7'(CAL_SAMPLES);
   assign status.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, yawo_ff, roll_ff, pitch_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= YAW_GAIN_RST;
      end else if (csr_wen) begin
         gain_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         gz_ff <= req_tdata[63:48];
      end
      if (cmd.square) begin
         sqy_ff <= sqy_full[30:0];
         sqz_ff <= sqz_full[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         calib_ff <= 1'b0;
         bias_ff  <= '0;
      end else if (cmd.cal_acc) begin
         count_ff <= count_ff + 1'b1;
         sum_ff   <= sum_ff + {{8{gz_ff[15]}}, gz_ff};
      end else if (cmd.bias_set) begin
         count_ff <= '0;
         sum_ff   <= '0;
         calib_ff <= 1'b1;
         bias_ff  <= neg_ff ? -quo_ff : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= num_abs;
         neg_ff <= sum_ff[23];
      end else if (cmd.div_step) begin
         quo_ff <= div_prod[DIV_SHIFT +: 24];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rad_ff  <= {1'b0, sqy_ff} + {1'b0, sqz_ff};
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[29:0], 2'b00};
         if (sq_t >= sq_trial) begin
            srem_ff <= 34'(sq_t - sq_trial);
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            srem_ff <= sq_t[33:0];
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cx_ff    <= az_ff[15] ? -az36 : az36;
         cy_ff    <= az_ff[15] ? -ax36 : ax36;
         cz_ff    <= !az_ff[15] ? 30'sd0 : (ax_ff[15] ? -ROLL_BASE : ROLL_BASE);
         czero_ff <= ax_ff == 16'sd0;
      end else if (cmd.pitch_load) begin
         rollz_ff <= cz_ff;
         cx_ff    <= $signed({4'b0, root_ff});
         cy_ff    <= -ax36;
         cz_ff    <= '0;
         czero_ff <= ax_ff == 16'sd0;
      end else if (cmd.cordic_step && !czero_ff) begin
         if (!cy_ff[35]) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + atan_v;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - atan_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         prod_ff <= diff * $signed({1'b0, gain_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff <= '0;
      end else if (cmd.pitch_load) begin
         yaw_ff <= yaw_ff + 42'(prod_ff >>> 8);
      end else if (cmd.yaw_wrap) begin
         if (yaw_ff >= YAW_HALF) begin
            yaw_ff <= yaw_ff - YAW_FULL;
         end else if (yaw_ff <= -YAW_HALF) begin
            yaw_ff <= yaw_ff + YAW_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pitch_ff <= pitch_sat[14:0];
         roll_ff  <= roll_sat[15:0];
         yawo_ff  <= yaw_rnd[40:25];
      end
   end

endmodule
